FILE: rtl/adcseq_pkg.sv
// adcseq_pkg: shared types and constants for the adc scan sequencer with agc
// no dependencies; imported by adc_scan_sequencer_with_agc
package adcseq_pkg;

  // default module parameters
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 12;

  // fixed result field widths
  localparam int VALUE_W = 12;
  localparam int GAIN_W  = 12;
  localparam int FUNC_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int OUT_W   = 40;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 5;
  localparam int LIMIT_W    = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDSCALE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INCL_SUPPLY  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PSU_COUNT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SUPPLY_COUNT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT  = 3'd6;

  // register reset values
  localparam int MIN_LEVEL_RST = 0;
  localparam int MAX_LEVEL_RST = 4095;
  localparam int MIDSCALE_RST  = 2048;
  localparam logic [COUNT_W-1:0] PSU_COUNT_RST    = 5'd12;
  localparam logic [COUNT_W-1:0] SUPPLY_COUNT_RST = 5'd14;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST  = 3'd3;

  // gain factor asked for on a zero sample
  localparam int ZERO_FACTOR = 3;

  // scan functions
  localparam logic [FUNC_W-1:0] FN_VOLTAGE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CURRENT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SUPPLY  = 2'd2;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [CHAN_W-1:0]  next_channel;
    logic [FUNC_W-1:0]  next_function;
    logic [GAIN_W-1:0]  gain_factor;
    logic               gain_to_minimum;
    logic [CHAN_W-1:0]  sample_channel;
    logic [FUNC_W-1:0]  sample_function;
    logic [VALUE_W-1:0] sample_value;
    logic               accepted;
  } out_item_t;

endpackage

FILE: rtl/adc_scan_sequencer_with_agc.sv
// adc_scan_sequencer_with_agc: sample check, scan advance and serial gain divider
// depends on adcseq_pkg
//
// Usage:
// - in_* takes one request per converter sample: the sample count in the low
//   SAMPLE_BITS of in_tdata and the gain-at-maximum flag just above it.
// - out_* gives one result per request: accept flag, the sample tagged with
//   its function and channel, the gain command and the next mux setting.
// - cfg_* writes one register per request (index, data); always ready. The
//   user must write only while the block is idle; the block does not enforce it.
// Flow through the block:
// - an accepted sample, or a zero one, is registered in the work stage and
//   moves into the output register, onto out_tvalid, once that is free; a
//   rejected nonzero sample first runs the restoring divider for the gain
//   factor, one quotient bit a cycle.
// - in_tready is high only while no sample is in work (state idle).
// - the output register frees the work stage: a new request is taken while
//   a result still waits for out_tready. A stalled receiver holds the block
//   once the next result is finished too.
// Reset clears the scan to voltage, channel 0, the retry count to 0 and the
// registers to their defaults; no result is pending afterwards.
module adc_scan_sequencer_with_agc
  import adcseq_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fields from bit 0: sample, gain_at_max, zero fill
  input  logic [((SAMPLE_BITS+1+7)/8)*8-1:0] in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fields from bit 0: accepted, sample_value, sample_function, sample_channel,
  // gain_to_minimum, gain_factor, next_function, next_channel, zero fill
  output logic [OUT_W-1:0]      out_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CH_W   = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = ((CH_W > COUNT_W) ? CH_W : COUNT_W) + 1;
  localparam int ITER_W = $clog2(SB + 1);
  localparam int WIDE_W = (SB > GAIN_W) ? SB : GAIN_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

  // configuration registers
  logic [SB-1:0]      min_level_r, max_level_r, midscale_r;
  logic               incl_supply_r;
  logic [COUNT_W-1:0] psu_count_r, supply_count_r;
  logic [LIMIT_W-1:0] retry_limit_r;

  // scan state
  logic [LIMIT_W-1:0] retry_r;
  logic [FUNC_W-1:0]  func_r;
  logic [CH_W-1:0]    chan_r;

  // work stage and divider
  state_t             state_r;
  out_item_t          res_r;
  logic [SB-1:0]      rem_r, quo_r, dvs_r;
  logic [ITER_W-1:0]  iter_r;

  // output register
  logic               out_valid_r;
  out_item_t          out_r;
  logic               out_load;

  // input fields
  logic [SB-1:0]      smp;
  logic               at_max;
  assign smp    = in_tdata[SB-1:0];
  assign at_max = in_tdata[SB];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-$bits(out_item_t)){1'b0}}, out_r};

  // finished result moves into the output register when it is free
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  // sample check
  logic [LIMIT_W:0] tries;
  logic             smp_ok, acc;
  assign tries  = {1'b0, retry_r} + 1'b1;
  assign smp_ok = ((smp > min_level_r) || at_max) && (smp < max_level_r);
  assign acc    = smp_ok || (tries > {1'b0, retry_limit_r});

  // effective channel counts: zero acts as one, capped at MAX_CHANNELS
  logic [CNT_W-1:0] psu_e, sup_e, psu_eff, sup_eff;
  assign psu_e = CNT_W'(psu_count_r);
  assign sup_e = CNT_W'(supply_count_r);
  always_comb begin
    psu_eff = psu_e;
    if (psu_e == '0) begin
      psu_eff = CNT_W'(1);
    end else if (psu_e > CNT_W'(MAX_CHANNELS)) begin
      psu_eff = CNT_W'(MAX_CHANNELS);
    end
    sup_eff = sup_e;
    if (sup_e == '0) begin
      sup_eff = CNT_W'(1);
    end else if (sup_e > CNT_W'(MAX_CHANNELS)) begin
      sup_eff = CNT_W'(MAX_CHANNELS);
    end
  end

  // next channel and function after an accepted sample
  logic [CNT_W-1:0]  ch_inc;
  logic [CH_W-1:0]   chan_nxt;
  logic [FUNC_W-1:0] func_nxt;
  always_comb begin
    ch_inc   = CNT_W'(chan_r) + 1'b1;
    chan_nxt = ch_inc[CH_W-1:0];
    func_nxt = func_r;
    if (incl_supply_r) begin
      if (((func_r <= FN_CURRENT) && (ch_inc >= psu_eff)) || (ch_inc >= sup_eff)) begin
        chan_nxt = '0;
        func_nxt = (func_r >= FN_SUPPLY) ? FN_VOLTAGE : func_r + 1'b1;
      end
    end else if (ch_inc >= psu_eff) begin
      chan_nxt = '0;
      func_nxt = (func_r == FN_VOLTAGE) ? FN_CURRENT : FN_VOLTAGE;
    end
  end

  // channel numbers as result fields
  logic [CNT_W-1:0] ch_cur_e, ch_nxt_e;
  assign ch_cur_e = CNT_W'(chan_r);
  assign ch_nxt_e = CNT_W'(chan_nxt);

  logic [WIDE_W-1:0] smp_e;
  assign smp_e = WIDE_W'(smp);

  // divider step: shift one dividend bit into the remainder, trial subtract
  logic [SB:0]       shifted;
  logic              ge;
  logic [SB:0]       diff;
  logic [SB-1:0]     rem_nxt, quo_nxt;
  logic [WIDE_W-1:0] quo_e;
  always_comb begin
    shifted = {rem_r, quo_r[SB-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? diff[SB-1:0] : shifted[SB-1:0];
    quo_nxt = {quo_r[SB-2:0], ge};
    quo_e   = WIDE_W'(quo_nxt);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r    <= SB'(MIN_LEVEL_RST);
      max_level_r    <= SB'(MAX_LEVEL_RST);
      midscale_r     <= SB'(MIDSCALE_RST);
      incl_supply_r  <= 1'b0;
      psu_count_r    <= PSU_COUNT_RST;
      supply_count_r <= SUPPLY_COUNT_RST;
      retry_limit_r  <= RETRY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_MIN_LEVEL:    min_level_r    <= cfg_data[SB-1:0];
        REG_MAX_LEVEL:    max_level_r    <= cfg_data[SB-1:0];
        REG_MIDSCALE:     midscale_r     <= cfg_data[SB-1:0];
        REG_INCL_SUPPLY:  incl_supply_r  <= cfg_data[0];
        REG_PSU_COUNT:    psu_count_r    <= cfg_data[COUNT_W-1:0];
        REG_SUPPLY_COUNT: supply_count_r <= cfg_data[COUNT_W-1:0];
        REG_RETRY_LIMIT:  retry_limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      retry_r     <= '0;
      func_r      <= FN_VOLTAGE;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      // output register fills or drains
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            res_r.accepted        <= acc;
            res_r.sample_value    <= smp_e[VALUE_W-1:0];
            res_r.sample_function <= func_r;
            res_r.sample_channel  <= ch_cur_e[CHAN_W-1:0];
            res_r.gain_to_minimum <= acc;
            dvs_r                 <= smp;
            quo_r                 <= midscale_r;
            rem_r                 <= '0;
            iter_r                <= ITER_W'(SB);
            if (acc) begin
              retry_r              <= '0;
              chan_r               <= chan_nxt;
              func_r               <= func_nxt;
              res_r.next_function  <= func_nxt;
              res_r.next_channel   <= ch_nxt_e[CHAN_W-1:0];
              res_r.gain_factor    <= '0;
              state_r              <= ST_HOLD;
            end else begin
              retry_r              <= tries[LIMIT_W-1:0];
              res_r.next_function  <= func_r;
              res_r.next_channel   <= ch_cur_e[CHAN_W-1:0];
              if (smp == '0) begin
                res_r.gain_factor <= GAIN_W'(ZERO_FACTOR);
                state_r           <= ST_HOLD;
              end else begin
                state_r           <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          iter_r <= iter_r - 1'b1;
          if (iter_r == ITER_W'(1)) begin
            res_r.gain_factor <= quo_e[GAIN_W-1:0];
            state_r           <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
